[rtl/str_pkg.sv]
package str_pkg;

   typedef enum logic [1:0] {
      CMD_STROKE = 2'd0,
      CMD_READ   = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   localparam logic [2:0] REG_ORIGIN_X = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [2:0] REG_AREA_W   = 3'd2;
   localparam logic [2:0] REG_AREA_H   = 3'd3;
   localparam logic [2:0] REG_CELL     = 3'd4;
   localparam logic [2:0] REG_TOL      = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVX,
      ST_DIVY,
      ST_CELL,
      ST_TEST,
      ST_DONE
   } state_type;

endpackage

[rtl/str_divider.sv]
// Restoring signed divider, one quotient bit a cycle, C truncation.
module str_divider #(
   parameter int W = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [W-1:0] num,
   input  logic        [W-1:0] den,
   output logic                busy,
   output logic signed [W-1:0] quo
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  rem_ff, rem_in, q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, neg_ff, neg_in;
   logic [W-1:0]  d_ff, d_in;
   logic [W:0]    trial;

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      d_in    = d_ff;
      trial   = '0;
      if (start) begin
         neg_in  = num[W-1];
         q_in    = num[W-1] ? -num : num;
         rem_in  = '0;
         d_in    = den;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, q_ff[W-1]} - {1'b0, d_ff};
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            q_in   = {q_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], q_ff[W-1]};
            q_in   = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
      d_ff   <= d_in;
   end

   assign busy = busy_ff;
   assign quo  = neg_ff ? -q_ff : q_ff;
endmodule

[rtl/str_front.sv]
// Accepts words and queues them for the back end.
module str_front #(
   parameter int QW = 64,
   parameter int DEPTH = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [QW-1:0] in_data,
   output logic          q_valid,
   input  logic          q_ready,
   output logic [QW-1:0] q_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [QW-1:0] mem [DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          push, pop;

   assign in_ready = (cnt_ff != (AW+1)'(DEPTH));
   assign q_valid  = (cnt_ff != '0);
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;
   assign q_data   = mem[rp_ff];

   always_comb begin
      wp_in  = push ? ((wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in  = pop ? ((rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem[wp_ff] <= in_data;
   end
endmodule

[rtl/stroke_to_grid_rasterizer.sv]
// A read or clear word is written into the front queue, taken by the back end when idle and
// answered from the registered output; a stroke walks steps+1 points, its time set by four
// serial divisions and nine cell tests for every point.
// The back end takes one word at a time; a two-entry queue sits in front.
// Reset (synchronous, active high) marks every grid row empty and loads register defaults.
module stroke_to_grid_rasterizer #(
   parameter int GRID_ROWS  = 36,
   parameter int GRID_COLS  = 24,
   parameter int COORD_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_tdata, from bit 0: pen_down, cur_x, cur_y, prev_x, prev_y, row_index
   input  logic [((1+4*COORD_BITS+6+7)/8)*8-1:0] req_tdata,
   // req_tuser: command
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rsp_tdata, from bit 0: row_bits
   output logic [23:0] rsp_tdata,
   // rsp_tuser: stroke_applied
   output logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int CB = COORD_BITS;
   localparam int DW = 1 + 4*CB + 6;
   localparam int QW = DW + 2;
   // Wide enough for prev + d*i, signed, and for grid indices.
   localparam int NW = 2*CB + 4;
   localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int CWD = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;

   // ---------------- configuration registers ----------------
   logic [11:0] ox_ff, oy_ff, aw_ff, ah_ff;
   logic [7:0]  cs_ff, tol_ff;
   logic        wr;
   logic [2:0]  ridx;

   assign csr_pready = 1'b1;
   assign wr   = csr_psel && csr_penable && csr_pwrite;
   assign ridx = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         ox_ff <= 12'd596; oy_ff <= 12'd238; aw_ff <= 12'd408; ah_ff <= 12'd612;
         cs_ff <= 8'd17;   tol_ff <= 8'd10;
      end else if (wr) begin
         case (ridx)
            str_pkg::REG_ORIGIN_X: ox_ff  <= csr_pwdata[11:0];
            str_pkg::REG_ORIGIN_Y: oy_ff  <= csr_pwdata[11:0];
            str_pkg::REG_AREA_W:   aw_ff  <= csr_pwdata[11:0];
            str_pkg::REG_AREA_H:   ah_ff  <= csr_pwdata[11:0];
            str_pkg::REG_CELL:     cs_ff  <= csr_pwdata[7:0];
            str_pkg::REG_TOL:      tol_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ridx)
         str_pkg::REG_ORIGIN_X: csr_prdata = {20'd0, ox_ff};
         str_pkg::REG_ORIGIN_Y: csr_prdata = {20'd0, oy_ff};
         str_pkg::REG_AREA_W:   csr_prdata = {20'd0, aw_ff};
         str_pkg::REG_AREA_H:   csr_prdata = {20'd0, ah_ff};
         str_pkg::REG_CELL:     csr_prdata = {24'd0, cs_ff};
         str_pkg::REG_TOL:      csr_prdata = {24'd0, tol_ff};
         default:               csr_prdata = '0;
      endcase
   end

   // ---------------- front queue ----------------
   logic          q_valid, q_ready;
   logic [QW-1:0] q_data;

   str_front #(.QW(QW), .DEPTH(2)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_data({req_tuser, req_tdata[DW-1:0]}),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
   );

   // ---------------- back end ----------------
   str_pkg::state_type st_ff, st_in;
   logic [CB-1:0]   px_ff, py_ff;
   logic [CB:0]     steps_ff, i_ff;
   logic signed [NW-1:0] dx_ff, dy_ff;
   logic signed [NW-1:0] x_ff, y_ff;   // current point
   logic signed [NW-1:0] col_ff, row_ff;
   logic [1:0]      r_off_ff, c_off_ff; // neighbour offset 0..2 means -1..+1
   // Grid rows are only trusted while their valid flag is set, so a clear just
   // drops the flags and a row that has not been written since reads as zero.
   logic [GRID_COLS-1:0] grid [GRID_ROWS];
   logic [GRID_ROWS-1:0] row_vld_ff;
   logic [GRID_COLS-1:0] row_rd_ff;    // stored copy of the row under test
   logic [GRID_COLS-1:0] row_acc_ff;   // cells set so far in that row
   logic            out_v_ff;
   logic [23:0]     out_bits_ff;
   logic            out_app_ff;
   logic            out_load;

   // Divider shared for point interpolation and cell index.
   logic                 dv_start, dv_busy;
   logic signed [NW-1:0] dv_num, dv_quo;
   logic [NW-1:0]        dv_den;
   logic                 div_phase_ff; // 0: interpolation, 1: cell index

   str_divider #(.W(NW)) u_div (
      .clock(clock), .reset(reset), .start(dv_start),
      .num(dv_num), .den(dv_den), .busy(dv_busy), .quo(dv_quo)
   );

   logic [7:0]  cs_eff;
   assign cs_eff = (cs_ff == 8'd0) ? 8'd1 : cs_ff;

   logic [1:0]     q_cmd;
   logic           q_pen;
   logic [CB-1:0]  q_cx, q_cy, q_px, q_py;
   logic [5:0]     q_ri;
   assign q_pen = q_data[0];
   assign q_cx  = q_data[CB:1];
   assign q_cy  = q_data[2*CB:CB+1];
   assign q_px  = q_data[3*CB:2*CB+1];
   assign q_py  = q_data[4*CB:3*CB+1];
   assign q_ri  = q_data[4*CB+6:4*CB+1];
   assign q_cmd = q_data[QW-1:DW];

   logic in_area, walk_go;
   assign in_area = ({1'b0, q_cx} >= {1'b0, ox_ff}) &&
                    ({1'b0, q_cx} < ({1'b0, ox_ff} + {1'b0, aw_ff})) &&
                    ({1'b0, q_cy} >= {1'b0, oy_ff}) &&
                    ({1'b0, q_cy} < ({1'b0, oy_ff} + {1'b0, ah_ff}));
   assign walk_go = (q_cmd == str_pkg::CMD_STROKE) && q_pen && in_area;

   logic signed [NW-1:0] qdx, qdy, adx, ady;
   assign qdx = NW'($signed({1'b0, q_cx})) - NW'($signed({1'b0, q_px}));
   assign qdy = NW'($signed({1'b0, q_cy})) - NW'($signed({1'b0, q_py}));
   assign adx = qdx[NW-1] ? -qdx : qdx;
   assign ady = qdy[NW-1] ? -qdy : qdy;

   // Neighbour cell test.
   logic signed [NW-1:0] rr, cc, by, bx, tol_s, cs_s;
   logic row_ok, col_ok, row_in;
   logic [RW-1:0] rr_idx;
   logic [GRID_COLS-1:0] cell_mask;
   assign tol_s  = NW'($signed({1'b0, tol_ff}));
   assign cs_s   = NW'($signed({1'b0, cs_eff}));
   assign rr     = row_ff + NW'($signed({1'b0, r_off_ff})) - NW'(1);
   assign cc     = col_ff + NW'($signed({1'b0, c_off_ff})) - NW'(1);
   assign by     = NW'($signed({1'b0, oy_ff})) + NW'(rr * cs_s);
   assign bx     = NW'($signed({1'b0, ox_ff})) + NW'(cc * cs_s);
   assign row_in = !rr[NW-1] && (rr < NW'(GRID_ROWS));
   assign rr_idx = rr[RW-1:0];
   assign row_ok = row_in && (y_ff >= by - tol_s) && (y_ff < by + cs_s + tol_s);
   assign col_ok = !cc[NW-1] && (cc < NW'(GRID_COLS)) &&
                   (x_ff >= bx - tol_s) && (x_ff < bx + cs_s + tol_s);
   assign cell_mask = (row_ok && col_ok) ? (GRID_COLS'(1) << cc[CWD-1:0]) : '0;

   logic sub_ff; // sub step inside a divide state: 0 start, 1 wait
   logic sub_in;
   logic out_free;
   assign out_free = !out_v_ff || rsp_tready;

   always_comb begin
      st_in    = st_ff;
      sub_in   = sub_ff;
      q_ready  = 1'b0;
      dv_start = 1'b0;
      dv_num   = '0;
      dv_den   = '0;
      out_load = 1'b0;
      case (st_ff)
         str_pkg::ST_IDLE: begin
            if (q_valid && out_free) begin
               q_ready = 1'b1;
               if (walk_go) begin
                  st_in  = str_pkg::ST_DIVX;
                  sub_in = 1'b0;
               end else begin
                  out_load = 1'b1;
               end
            end
         end
         str_pkg::ST_DIVX, str_pkg::ST_DIVY: begin
            if (!sub_ff) begin
               dv_start = 1'b1;
               if (!div_phase_ff) begin
                  dv_num = NW'((st_ff == str_pkg::ST_DIVX ? dx_ff : dy_ff) *
                               $signed({1'b0, i_ff}));
                  dv_den = NW'(steps_ff);
               end else begin
                  dv_num = (st_ff == str_pkg::ST_DIVX)
                         ? x_ff - NW'($signed({1'b0, ox_ff}))
                         : y_ff - NW'($signed({1'b0, oy_ff}));
                  dv_den = NW'(cs_eff);
               end
               sub_in = 1'b1;
            end else if (!dv_busy) begin
               sub_in = 1'b0;
               if (st_ff == str_pkg::ST_DIVX) st_in = str_pkg::ST_DIVY;
               else st_in = div_phase_ff ? str_pkg::ST_TEST : str_pkg::ST_CELL;
            end
         end
         str_pkg::ST_CELL: st_in = str_pkg::ST_DIVX;
         str_pkg::ST_TEST: begin
            if (r_off_ff == 2'd2 && c_off_ff == 2'd2) begin
               st_in = (i_ff == steps_ff) ? str_pkg::ST_DONE : str_pkg::ST_DIVX;
            end
         end
         str_pkg::ST_DONE: begin
            if (out_free) begin
               st_in    = str_pkg::ST_IDLE;
               out_load = 1'b1;
            end
         end
         default: st_in = str_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= str_pkg::ST_IDLE;
         sub_ff       <= 1'b0;
         out_v_ff     <= 1'b0;
         div_phase_ff <= 1'b0;
         row_vld_ff   <= '0;
      end else begin
         st_ff  <= st_in;
         sub_ff <= sub_in;
         if (out_load) out_v_ff <= 1'b1;
         else if (rsp_tready) out_v_ff <= 1'b0;
         case (st_ff)
            str_pkg::ST_IDLE: begin
               if (q_valid && out_free) begin
                  px_ff <= q_px; py_ff <= q_py;
                  dx_ff <= qdx; dy_ff <= qdy;
                  steps_ff <= (adx == '0 && ady == '0) ? (CB+1)'(1)
                            : (adx > ady ? (CB+1)'(adx) : (CB+1)'(ady));
                  i_ff <= '0;
                  div_phase_ff <= 1'b0;
                  if (!walk_go) begin
                     // The stroke result is given at the end of the walk instead.
                     out_app_ff  <= 1'b0;
                     out_bits_ff <= (q_cmd == str_pkg::CMD_READ && q_ri < 6'(GRID_ROWS) &&
                                     row_vld_ff[q_ri[RW-1:0]])
                                  ? 24'(grid[q_ri[RW-1:0]]) : '0;
                     if (q_cmd == str_pkg::CMD_CLEAR) row_vld_ff <= '0;
                  end
               end
            end
            str_pkg::ST_DIVX: if (sub_ff && !dv_busy) begin
               if (!div_phase_ff) x_ff <= NW'($signed({1'b0, px_ff})) + dv_quo;
               else col_ff <= dv_quo;
            end
            str_pkg::ST_DIVY: if (sub_ff && !dv_busy) begin
               if (!div_phase_ff) y_ff <= NW'($signed({1'b0, py_ff})) + dv_quo;
               else begin
                  row_ff <= dv_quo;
                  r_off_ff <= 2'd0;
                  c_off_ff <= 2'd0;
               end
            end
            str_pkg::ST_CELL: div_phase_ff <= 1'b1;
            str_pkg::ST_TEST: begin
               // Each neighbour row is read on its first column test and written
               // back, with the new cells merged in, on its last.
               if (c_off_ff == 2'd0) begin
                  row_rd_ff  <= (row_in && row_vld_ff[rr_idx]) ? grid[rr_idx] : '0;
                  row_acc_ff <= cell_mask;
               end else if (c_off_ff == 2'd2) begin
                  if (row_in) begin
                     grid[rr_idx]       <= row_rd_ff | row_acc_ff | cell_mask;
                     row_vld_ff[rr_idx] <= 1'b1;
                  end
               end else begin
                  row_acc_ff <= row_acc_ff | cell_mask;
               end
               if (c_off_ff == 2'd2) begin
                  c_off_ff <= 2'd0;
                  r_off_ff <= r_off_ff + 2'd1;
               end else c_off_ff <= c_off_ff + 2'd1;
               if (r_off_ff == 2'd2 && c_off_ff == 2'd2) begin
                  i_ff <= i_ff + 1'b1;
                  div_phase_ff <= 1'b0;
               end
            end
            str_pkg::ST_DONE: if (out_free) begin
               out_app_ff  <= 1'b1;
               out_bits_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_bits_ff;
   assign rsp_tuser  = out_app_ff;

`ifndef SYNTH
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (st_ff == str_pkg::ST_IDLE) |-> !dv_busy) else $error("divider busy in idle");
   a_done_out: assert property (@(posedge clock) disable iff (reset)
      (st_ff == str_pkg::ST_DONE && out_free) |=> (rsp_tvalid && rsp_tuser))
      else $error("stroke result lost");
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (st_ff == str_pkg::ST_TEST) |-> (i_ff <= steps_ff)) else $error("walk overrun");
`endif
endmodule
